FILE: rtl/core/pokr_pkg.sv
// Package for the post-order key reorder block: field widths, controller
// states and the command/status bundles between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps

package pokr_pkg;

   localparam int KEY_WIDTH        = 16;
   localparam int VALUE_PORT_WIDTH = 32;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_FETCH,
      ST_DECIDE,
      ST_FILL,
      ST_EMIT
   } pokr_state_type;

   typedef struct packed {
      logic load;   // input transaction accepted this cycle
      logic fetch;  // start the reorder pass
      logic step;   // one pop, push or copy step
      logic fill;   // move one stack entry to the front
      logic emit;   // read one sorted entry out
   } pokr_cmd_type;

   typedef struct packed {
      logic pop;        // next key below stack top
      logic push_ok;    // stack has room
      logic rd_zero;    // read pointer at the front
      logic fill_last;  // last stack entry being moved
      logic emit_last;  // last entry being read out
   } pokr_status_type;

endpackage

FILE: rtl/core/pokr_ctrl.sv
// Controller for the post-order key reorder block: sequences load, reorder,
// stack fill and emit phases. Depends on pokr_pkg.
`timescale 1ns / 1ps

module pokr_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic                     req_is_last,
   input  pokr_pkg::pokr_status_type status,
   output pokr_pkg::pokr_cmd_type    cmd,
   output logic                     busy
);
   import pokr_pkg::*;

   pokr_state_type state_ff;
   pokr_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (start && req_is_last) state_in = ST_FETCH;
         end
         ST_FETCH: begin
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            // a pop keeps the current item; otherwise the item is consumed
            if (!status.pop && status.rd_zero) state_in = ST_FILL;
         end
         ST_FILL: begin
            if (status.fill_last) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.emit_last) state_in = ST_LOAD;
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      unique case (state_ff)
         ST_LOAD: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         ST_FETCH:  cmd.fetch = 1'b1;
         ST_DECIDE: cmd.step  = 1'b1;
         ST_FILL:   cmd.fill  = 1'b1;
         ST_EMIT:   cmd.emit  = 1'b1;
         default: begin
            busy = 1'b1;
         end
      endcase
   end

endmodule

FILE: rtl/core/pokr_dp.sv
// Datapath for the post-order key reorder block: item memory, bounded stack,
// pointers and the registered result stage. Depends on pokr_pkg.
`timescale 1ns / 1ps

module pokr_dp #(
   parameter int MAX_ITEMS   = 64,
   parameter int STACK_DEPTH = 16,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  pokr_pkg::pokr_cmd_type                   cmd,
   output pokr_pkg::pokr_status_type                status,
   input  logic [pokr_pkg::KEY_WIDTH-1:0]           req_item_key,
   input  logic [pokr_pkg::VALUE_PORT_WIDTH-1:0]    req_item_value,
   output logic                                     rsp_valid,
   output logic [pokr_pkg::KEY_WIDTH-1:0]           rsp_out_key,
   output logic [pokr_pkg::VALUE_PORT_WIDTH-1:0]    rsp_out_value,
   output logic                                     rsp_out_last,
   output logic                                     rsp_items_dropped
);
   import pokr_pkg::*;

   localparam int VW = (VALUE_WIDTH < VALUE_PORT_WIDTH) ? VALUE_WIDTH : VALUE_PORT_WIDTH;
   localparam int EW = KEY_WIDTH + VW;
   localparam int CW = $clog2(MAX_ITEMS + 1);
   localparam int AW = $clog2(MAX_ITEMS);
   localparam int DW = $clog2(STACK_DEPTH + 1);
   localparam int SW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

   logic [EW-1:0] item_mem [MAX_ITEMS];
   logic [EW-1:0] stack_ff [STACK_DEPTH];

   logic [EW-1:0] mem_rd_ff;
   logic [CW-1:0] count_ff,   count_in;
   logic          ovf_ff,     ovf_in;
   logic [AW-1:0] rd_ff,      rd_in;
   logic [AW-1:0] wr_ff,      wr_in;
   logic [DW-1:0] depth_ff,   depth_in;
   logic [DW-1:0] fill_ff,    fill_in;
   logic [AW-1:0] emit_ff,    emit_in;
   logic          valid_ff,   valid_in;
   logic          last_ff,    last_in;
   logic          dropped_ff, dropped_in;

   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [EW-1:0] mem_wdata;
   logic          mem_re;
   logic [AW-1:0] mem_raddr;
   logic          stack_we;
   logic [EW-1:0] top_entry;
   logic [KEY_WIDTH-1:0] cur_key;
   logic [KEY_WIDTH-1:0] top_key;

   always_comb begin
      top_entry = stack_ff[SW'(depth_ff - DW'(1))];
      cur_key   = mem_rd_ff[EW-1 -: KEY_WIDTH];
      top_key   = top_entry[EW-1 -: KEY_WIDTH];

      status.pop       = (depth_ff != '0) && (cur_key < top_key);
      status.push_ok   = depth_ff < DW'(STACK_DEPTH);
      status.rd_zero   = rd_ff == '0;
      status.fill_last = fill_ff == (depth_ff - DW'(1));
      status.emit_last = CW'(emit_ff) == (count_ff - CW'(1));

      mem_we     = 1'b0;
      mem_waddr  = wr_ff;
      mem_wdata  = mem_rd_ff;
      mem_re     = 1'b0;
      mem_raddr  = rd_ff - AW'(1);
      stack_we   = 1'b0;
      count_in   = count_ff;
      ovf_in     = ovf_ff;
      rd_in      = rd_ff;
      wr_in      = wr_ff;
      depth_in   = depth_ff;
      fill_in    = fill_ff;
      emit_in    = emit_ff;
      valid_in   = 1'b0;
      last_in    = last_ff;
      dropped_in = dropped_ff;

      if (cmd.load) begin
         if (count_ff < CW'(MAX_ITEMS)) begin
            mem_we    = 1'b1;
            mem_waddr = AW'(count_ff);
            mem_wdata = {req_item_key, VW'(req_item_value)};
            count_in  = count_ff + CW'(1);
         end else begin
            ovf_in = 1'b1;
         end
      end

      if (cmd.fetch) begin
         mem_re    = 1'b1;
         mem_raddr = AW'(count_ff - CW'(1));
         rd_in     = AW'(count_ff - CW'(1));
         wr_in     = AW'(count_ff - CW'(1));
         depth_in  = '0;
         fill_in   = '0;
         emit_in   = '0;
      end

      if (cmd.step) begin
         if (status.pop) begin
            // hold the current item, move the stack top to the write slot
            mem_we    = 1'b1;
            mem_wdata = top_entry;
            depth_in  = depth_ff - DW'(1);
            wr_in     = wr_ff - AW'(1);
         end else begin
            mem_re = !status.rd_zero;
            rd_in  = rd_ff - AW'(1);
            if (status.push_ok) begin
               stack_we = 1'b1;
               depth_in = depth_ff + DW'(1);
            end else begin
               mem_we = 1'b1;
               wr_in  = wr_ff - AW'(1);
            end
         end
      end

      if (cmd.fill) begin
         mem_we    = 1'b1;
         mem_waddr = AW'(fill_ff);
         mem_wdata = stack_ff[SW'(fill_ff)];
         fill_in   = fill_ff + DW'(1);
      end

      if (cmd.emit) begin
         mem_re     = 1'b1;
         mem_raddr  = emit_ff;
         emit_in    = emit_ff + AW'(1);
         valid_in   = 1'b1;
         last_in    = status.emit_last;
         dropped_in = ovf_ff;
         if (status.emit_last) begin
            count_in = '0;
            ovf_in   = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) item_mem[mem_waddr] <= mem_wdata;
      if (mem_re) mem_rd_ff <= item_mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (stack_we) stack_ff[SW'(depth_ff)] <= mem_rd_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ovf_ff   <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_ff      <= rd_in;
      wr_ff      <= wr_in;
      depth_ff   <= depth_in;
      fill_ff    <= fill_in;
      emit_ff    <= emit_in;
      last_ff    <= last_in;
      dropped_ff <= dropped_in;
   end

   assign rsp_valid         = valid_ff;
   assign rsp_out_key       = mem_rd_ff[EW-1 -: KEY_WIDTH];
   assign rsp_out_value     = VALUE_PORT_WIDTH'(mem_rd_ff[VW-1:0]);
   assign rsp_out_last      = last_ff;
   assign rsp_items_dropped = dropped_ff;

endmodule

FILE: rtl/core/post_order_key_reorder_top.sv
// Top level of the post-order key reorder block: joins controller and
// datapath. Depends on pokr_pkg, pokr_ctrl and pokr_dp.
//
// Usage: drive an item on req_item_key/req_item_value/req_is_last and pulse
// start; the transaction is taken at a clock edge where start is high and
// busy is low. Items of a run load at one per cycle with busy low. Up to
// MAX_ITEMS items are kept; later ones are dropped, and every result of that
// run then carries rsp_items_dropped. The item with req_is_last closes the
// run and raises busy.
// The run of N items is then sorted in the single item memory: a fetch
// step, then steps that each consume one of the N items or pop the stack,
// then one step per stack entry (at most STACK_DEPTH) to move the stack to
// the front. Results follow at one per cycle, each shown for one cycle with
// rsp_valid, the final one with rsp_out_last. The memory's single write and
// single registered read port set this pace.
// busy falls as the final result is read out, so a new run may load while
// it is shown. The receiver cannot stall the result transactions.
// Reset (synchronous, active high) empties the run and idles the block.
`timescale 1ns / 1ps

module post_order_key_reorder_top #(
   parameter int MAX_ITEMS   = 64,
   parameter int STACK_DEPTH = 16,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [pokr_pkg::KEY_WIDTH-1:0]        req_item_key,
   input  logic [pokr_pkg::VALUE_PORT_WIDTH-1:0] req_item_value,
   input  logic                                  req_is_last,
   output logic                                  rsp_valid,
   output logic [pokr_pkg::KEY_WIDTH-1:0]        rsp_out_key,
   output logic [pokr_pkg::VALUE_PORT_WIDTH-1:0] rsp_out_value,
   output logic                                  rsp_out_last,
   output logic                                  rsp_items_dropped
);
   import pokr_pkg::*;

   pokr_cmd_type    cmd;
   pokr_status_type status;

   pokr_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_is_last (req_is_last),
      .status      (status),
      .cmd         (cmd),
      .busy        (busy)
   );

   pokr_dp #(
      .MAX_ITEMS   (MAX_ITEMS),
      .STACK_DEPTH (STACK_DEPTH),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_item_key      (req_item_key),
      .req_item_value    (req_item_value),
      .rsp_valid         (rsp_valid),
      .rsp_out_key       (rsp_out_key),
      .rsp_out_value     (rsp_out_value),
      .rsp_out_last      (rsp_out_last),
      .rsp_items_dropped (rsp_items_dropped)
   );

   // results of a run come out back to back
   a_emit_contiguous: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_out_last |=> rsp_valid)
      else $error("result stream broke before the last transaction");

   // closing a run locks out new input
   a_last_sets_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_is_last |=> busy)
      else $error("busy not raised after the closing transaction");

   // a result strobe only follows a read-out command
   a_valid_from_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(cmd.emit))
      else $error("result strobe without a read-out");

   // only one phase command at a time
   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0(cmd))
      else $error("overlapping datapath commands");

endmodule
